// ===== sv/aggwalk_pkg.sv =====
// Shared types, codes and constants of the aggregation walker step block.
`default_nettype none

package aggwalk_pkg;

    // Default sizes of the lattice and the walker table.
    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int NUM_WALKERS_DEF = 256;

    // Smallest lattice edge; narrower settings are raised to this.
    localparam int LATTICE_MIN = 3;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd2;

    localparam logic [8:0]  GRID_WIDTH_RST     = 9'd256;
    localparam logic [8:0]  GRID_HEIGHT_RST    = 9'd256;
    localparam logic [10:0] MOVE_THRESHOLD_RST = 11'd717;

    // Opcodes.
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_SPAWN = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // Turn directions.
    localparam logic [1:0] DIR_XPOS = 2'd0;
    localparam logic [1:0] DIR_YPOS = 2'd1;
    localparam logic [1:0] DIR_XNEG = 2'd2;
    localparam logic [1:0] DIR_YNEG = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] walker_index;
        logic [9:0] move_roll;
        logic [1:0] turn_direction;
        logic [1:0] spawn_corner;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       walker_alive;
        logic       just_settled;
    } t_out_beat;

    typedef struct packed {
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [10:0] move_threshold;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/aggregation_walker_step.sv =====
// Step operation: accept beat, walker read, multiply, index, four bitmap reads, settle, result;
// the single bitmap port serves the four neighbor reads in turn, and no new beat is taken until the result is loaded.
// Spawn, ignored beats and unused opcodes go straight to the result; stepping a dead walker reads the table first.
// Clear and seed sweeps the bitmap one entry a cycle, over all MAX_WIDTH*MAX_HEIGHT entries (65536).
// After reset the same sweep also clears the walker table; no beat is taken until it ends.
`default_nettype none

module aggregation_walker_step #(
    parameter int MAX_WIDTH   = aggwalk_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = aggwalk_pkg::MAX_HEIGHT_DEF,
    parameter int NUM_WALKERS = aggwalk_pkg::NUM_WALKERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  aggwalk_pkg::t_in_beat             i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output aggwalk_pkg::t_out_beat            o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aggwalk_pkg::PADDR_W-1:0]   paddr,
    input  logic [aggwalk_pkg::PDATA_W-1:0]   pwdata,
    output logic [aggwalk_pkg::PDATA_W-1:0]   prdata,
    output logic                              pready
);
    import aggwalk_pkg::*;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int WAW       = (NUM_WALKERS > 1) ? $clog2(NUM_WALKERS) : 1;
    localparam int SWEEP     = (MAP_DEPTH > NUM_WALKERS) ? MAP_DEPTH : NUM_WALKERS;
    localparam int CW        = $clog2(SWEEP + 1);
    localparam int WEW       = XW + YW + 3;
    localparam int WE_DXN    = XW + YW;
    localparam int WE_DYN    = XW + YW + 1;
    localparam int WE_LIVE   = XW + YW + 2;

    // Neighbor probe order.
    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SEED = 9'b000000010,
        S_CLR  = 9'b000000100,
        S_WRD  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_IDX  = 9'b000100000,
        S_NB   = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_PUT  = 9'b100000000
    } t_state;

    t_cfg cfg;

    t_state r_state, n_state;
    logic   r_clr_walk;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_seed_addr;

    logic [WAW-1:0] r_wa;
    logic [9:0]     r_roll;
    logic [1:0]     r_dir;
    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic           r_dxn, r_dyn;
    logic [AW-1:0]  r_prod;
    logic [AW-1:0]  r_idx;
    logic [1:0]     r_nb;
    logic           r_hit;
    t_out_beat      r_res;
    t_out_beat      r_out;
    logic           r_out_valid;

    logic [WW-1:0]  lat_w;
    logic [HW-1:0]  lat_h;
    logic [XW-1:0]  w_max;
    logic [YW-1:0]  h_max;

    logic           accept, out_free, wi_ok;
    logic [XW-1:0]  sp_x;
    logic [YW-1:0]  sp_y;

    logic [WEW-1:0] wk_rdata, wk_wdata;
    logic [WAW-1:0] wk_addr;
    logic           wk_we;
    logic [XW-1:0]  rd_x, xs, mx;
    logic [YW-1:0]  rd_y, ys, my;
    logic           rd_live, t_dxn, t_dyn;

    logic [AW-1:0]  map_addr;
    logic           map_we, map_wdata, map_rdata;
    logic [3:0]     guard;
    logic           hit_fin;

    aggwalk_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Lattice size, saturated to the supported range.
    always_comb begin
        if (32'(cfg.grid_width) < LATTICE_MIN) begin
            lat_w = WW'(LATTICE_MIN);
        end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
            lat_w = WW'(MAX_WIDTH);
        end else begin
            lat_w = WW'(cfg.grid_width);
        end
        if (32'(cfg.grid_height) < LATTICE_MIN) begin
            lat_h = HW'(LATTICE_MIN);
        end else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) begin
            lat_h = HW'(MAX_HEIGHT);
        end else begin
            lat_h = HW'(cfg.grid_height);
        end
    end

    assign w_max = XW'(lat_w - WW'(1));
    assign h_max = YW'(lat_h - HW'(1));

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign wi_ok      = 32'(i_in_data.walker_index) < 32'(NUM_WALKERS);

    // Corner bit 0 picks the right edge, bit 1 the bottom edge.
    assign sp_x = i_in_data.spawn_corner[0] ? w_max : '0;
    assign sp_y = i_in_data.spawn_corner[1] ? h_max : '0;

    // Walker table entry fields.
    assign rd_x    = wk_rdata[XW-1:0];
    assign rd_y    = wk_rdata[XW+YW-1:XW];
    assign rd_live = wk_rdata[WE_LIVE];

    // Turn if the roll is under the move threshold, clamp to the lattice, then move; a walker at an edge holds there.
    always_comb begin
        t_dxn = wk_rdata[WE_DXN];
        t_dyn = wk_rdata[WE_DYN];
        if ({1'b0, r_roll} < cfg.move_threshold) begin
            case (r_dir)
                DIR_XPOS: t_dxn = 1'b0;
                DIR_YPOS: t_dyn = 1'b0;
                DIR_XNEG: t_dxn = 1'b1;
                default:  t_dyn = 1'b1;
            endcase
        end
        xs = (rd_x > w_max) ? w_max : rd_x;
        ys = (rd_y > h_max) ? h_max : rd_y;
        if (t_dxn) begin
            mx = (xs == '0) ? xs : xs - XW'(1);
        end else begin
            mx = (xs == w_max) ? xs : xs + XW'(1);
        end
        if (t_dyn) begin
            my = (ys == '0) ? ys : ys - YW'(1);
        end else begin
            my = (ys == h_max) ? ys : ys + YW'(1);
        end
    end

    assign guard[NB_RIGHT] = r_x < w_max;
    assign guard[NB_LEFT]  = r_x != '0;
    assign guard[NB_UP]    = r_y != '0;
    assign guard[NB_DOWN]  = r_y < h_max;

    assign hit_fin = r_hit || (map_rdata && guard[NB_DOWN]);

    // Walker table port.
    always_comb begin
        wk_addr  = WAW'(i_in_data.walker_index);
        wk_we    = 1'b0;
        wk_wdata = {1'b1, 1'b0, 1'b0, sp_y, sp_x};
        if (r_state == S_IDLE) begin
            wk_we = accept && (i_in_data.opcode == OP_SPAWN) && wi_ok;
        end else if (r_state == S_CLR) begin
            wk_addr  = r_cnt[WAW-1:0];
            wk_we    = r_clr_walk && (r_cnt < CW'(NUM_WALKERS));
            wk_wdata = '0;
        end else if (r_state == S_FIN) begin
            wk_addr  = r_wa;
            wk_we    = 1'b1;
            wk_wdata = {!hit_fin, r_dyn, r_dxn, r_y, r_x};
        end
    end

    // Bitmap port: sweep, neighbor probes, settle.
    always_comb begin
        map_addr  = r_idx;
        map_we    = 1'b0;
        map_wdata = 1'b1;
        if (r_state == S_CLR) begin
            map_addr  = r_cnt[AW-1:0];
            map_we    = r_cnt < CW'(MAP_DEPTH);
            map_wdata = (r_cnt[AW-1:0] == r_seed_addr);
        end else if (r_state == S_NB) begin
            case (r_nb)
                NB_RIGHT: map_addr = r_idx + AW'(1);
                NB_LEFT:  map_addr = r_idx - AW'(1);
                NB_UP:    map_addr = r_idx - AW'(lat_w);
                default:  map_addr = r_idx + AW'(lat_w);
            endcase
        end else if (r_state == S_FIN) begin
            map_we = hit_fin;
        end
    end

    aggwalk_ram #(.WIDTH(WEW), .DEPTH(NUM_WALKERS)) u_walker_ram (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_addr  (wk_addr),
        .i_wdata (wk_wdata),
        .o_rdata (wk_rdata)
    );

    aggwalk_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (map_addr),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.opcode == OP_SEED) begin
                        n_state = S_SEED;
                    end else if (i_in_data.opcode == OP_STEP && wi_ok) begin
                        n_state = S_WRD;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_SEED: n_state = S_CLR;
            S_CLR: begin
                if (r_cnt == CW'(SWEEP - 1)) begin
                    n_state = r_clr_walk ? S_IDLE : S_PUT;
                end
            end
            S_WRD:  n_state = rd_live ? S_MUL : S_PUT;
            S_MUL:  n_state = S_IDX;
            S_IDX:  n_state = S_NB;
            S_NB:   n_state = (r_nb == NB_DOWN) ? S_FIN : S_NB;
            S_FIN:  n_state = S_PUT;
            S_PUT:  n_state = out_free ? S_IDLE : S_PUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SEED;
            r_clr_walk <= 1'b1;
            r_cnt      <= '0;
            r_nb       <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_clr_walk <= 1'b0;
                    end
                end
                S_SEED: r_cnt <= '0;
                S_CLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SWEEP - 1)) begin
                        r_clr_walk <= 1'b0;
                    end
                end
                S_IDX:  r_nb <= '0;
                S_NB:   r_nb <= r_nb + 2'd1;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_wa   <= WAW'(i_in_data.walker_index);
                r_roll <= i_in_data.move_roll;
                r_dir  <= i_in_data.turn_direction;
                if (i_in_data.opcode == OP_SPAWN && wi_ok) begin
                    r_res <= '{pos_x: 8'(sp_x), pos_y: 8'(sp_y),
                               walker_alive: 1'b1, just_settled: 1'b0};
                end else begin
                    r_res <= '0;
                end
            end
            S_SEED: begin
                r_seed_addr <= AW'(lat_w >> 1) + AW'(AW'(lat_h >> 1) * AW'(lat_w));
                r_res <= '{pos_x: 8'(lat_w >> 1), pos_y: 8'(lat_h >> 1),
                           walker_alive: 1'b0, just_settled: 1'b0};
            end
            S_WRD: begin
                r_x   <= mx;
                r_y   <= my;
                r_dxn <= t_dxn;
                r_dyn <= t_dyn;
                r_res <= '{pos_x: 8'(rd_x), pos_y: 8'(rd_y),
                           walker_alive: 1'b0, just_settled: 1'b0};
            end
            S_MUL: r_prod <= AW'(r_y) * AW'(lat_w);
            S_IDX: begin
                r_idx <= AW'(r_x) + r_prod;
                r_hit <= 1'b0;
            end
            S_NB: begin
                // Read data is registered, so it answers the probe issued in the cycle before.
                if (r_nb != NB_RIGHT) begin
                    r_hit <= r_hit || (map_rdata && guard[r_nb - 2'd1]);
                end
            end
            S_FIN: begin
                r_res <= '{pos_x: 8'(r_x), pos_y: 8'(r_y),
                           walker_alive: !hit_fin, just_settled: hit_fin};
            end
            default: ;
        endcase
    end

    // Output register; a new beat loads when the previous one has gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/aggwalk_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module aggwalk_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/aggwalk_cfg.sv =====
// APB-style configuration registers of the aggregation walker step block.
`default_nettype none

module aggwalk_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aggwalk_pkg::PADDR_W-1:0]   paddr,
    input  logic [aggwalk_pkg::PDATA_W-1:0]   pwdata,
    output logic [aggwalk_pkg::PDATA_W-1:0]   prdata,
    output logic                              pready,
    output aggwalk_pkg::t_cfg                 o_cfg
);
    import aggwalk_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width     <= GRID_WIDTH_RST;
            r_cfg.grid_height    <= GRID_HEIGHT_RST;
            r_cfg.move_threshold <= MOVE_THRESHOLD_RST;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_GRID_WIDTH:     r_cfg.grid_width     <= pwdata[8:0];
                REG_GRID_HEIGHT:    r_cfg.grid_height    <= pwdata[8:0];
                REG_MOVE_THRESHOLD: r_cfg.move_threshold <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_GRID_WIDTH:     prdata = PDATA_W'(r_cfg.grid_width);
            REG_GRID_HEIGHT:    prdata = PDATA_W'(r_cfg.grid_height);
            REG_MOVE_THRESHOLD: prdata = PDATA_W'(r_cfg.move_threshold);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
